FILE: hdl/atil_pkg.sv
// shared types and codes for the adjacency table insert and lookup core
package atil_pkg;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_LIST = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_SELF     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOROOM   = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_EMIT
  } state_t;

  // control part of the request token that walks the row chain
  typedef struct packed {
    logic    vld;
    logic    op;
    logic    done;
    status_t status;
  } tok_ctl_t;

endpackage

FILE: hdl/adjacency_table_insert_lookup_core.sv
// top level of the adjacency table: request entry, row cell chain, result sequencer
// a request walks all MAX_ROWS cells, one per cycle, then the output register; after that
//   one result per cycle goes out while out_stall is low
// one request at a time: in_stall holds new requests until the final result is taken
// reset: rst clears every row's in-use flag and fill count, the token and the sequencer
module adjacency_table_insert_lookup_core #(
  parameter int MAX_ROWS      = 16,
  parameter int MAX_NEIGHBORS = 8,
  parameter int NODE_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [15:0] node_a,
  input  logic [15:0] node_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] node_out,
  output logic        last
);
  import atil_pkg::*;

  localparam int FW = $clog2(MAX_NEIGHBORS + 1);

  typedef logic [MAX_NEIGHBORS-1:0][NODE_BITS-1:0] row_nbrs_t;

  state_t state;
  state_t state_next;

  // token links between cells; link 0 is the injection point, link MAX_ROWS the end
  tok_ctl_t             ctl_w  [MAX_ROWS+1];
  logic [NODE_BITS-1:0] a_w    [MAX_ROWS+1];
  logic [NODE_BITS-1:0] b_w    [MAX_ROWS+1];
  logic [NODE_BITS-1:0] src_w  [MAX_ROWS+1];
  logic [FW-1:0]        fill_w [MAX_ROWS+1];
  row_nbrs_t            nbrs_w [MAX_ROWS+1];

  tok_ctl_t             start;
  logic                 accept;
  logic [NODE_BITS-1:0] a_id;
  logic [NODE_BITS-1:0] b_id;

  // ids are compared at NODE_BITS bits
  assign a_id = NODE_BITS'(node_a);
  assign b_id = NODE_BITS'(node_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    // no request is taken while reset is held
    in_stall   = rst || (state != S_IDLE);
    accept     = in_valid && !in_stall;

    // inject the request token; a self edge is settled here and just rides along
    ctl_w[0].vld    = accept;
    ctl_w[0].op     = opcode;
    ctl_w[0].done   = (opcode == OP_ADD) && (a_id == b_id);
    ctl_w[0].status = ST_SELF;
    a_w[0]          = a_id;
    b_w[0]          = b_id;
    src_w[0]        = '0;
    fill_w[0]       = '0;
    nbrs_w[0]       = '0;

    // resolve the token at the chain end; unclaimed means table full or not found
    start = ctl_w[MAX_ROWS];
    if (!ctl_w[MAX_ROWS].done) begin
      start.status = (ctl_w[MAX_ROWS].op == OP_ADD) ? ST_NOROOM : ST_NOTFOUND;
    end
    start.vld = ctl_w[MAX_ROWS].vld && (state == S_WALK);

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (ctl_w[MAX_ROWS].vld) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        // back to idle once the final result of the request is taken
        if (out_valid && !out_stall && last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // row chain: rows are opened in cell order, so used cells form a prefix
  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    atil_cell #(
      .MAX_NEIGHBORS (MAX_NEIGHBORS),
      .NODE_BITS     (NODE_BITS),
      .FW            (FW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (ctl_w[g]),
      .a_in     (a_w[g]),
      .b_in     (b_w[g]),
      .src_in   (src_w[g]),
      .fill_in  (fill_w[g]),
      .nbrs_in  (nbrs_w[g]),
      .ctl_out  (ctl_w[g+1]),
      .a_out    (a_w[g+1]),
      .b_out    (b_w[g+1]),
      .src_out  (src_w[g+1]),
      .fill_out (fill_w[g+1]),
      .nbrs_out (nbrs_w[g+1])
    );
  end

  // output register and row readout
  atil_emit #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .NODE_BITS     (NODE_BITS),
    .FW            (FW)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .src_in    (src_w[MAX_ROWS]),
    .fill_in   (fill_w[MAX_ROWS]),
    .nbrs_in   (nbrs_w[MAX_ROWS]),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .node_out  (node_out),
    .last      (last)
  );

  // results only go out while the sequencer state says so
  a_out_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_EMIT))
    else $error("result valid outside emit state");

  // the token reaches the chain end only during the walk
  a_tok_in_walk: assert property (@(posedge clk) disable iff (rst)
    ctl_w[MAX_ROWS].vld |-> (state == S_WALK))
    else $error("token at chain end outside walk state");

  // an accepted request always starts a walk
  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_WALK))
    else $error("accepted request did not start a walk");

  // nothing follows the final result of a request
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> !out_valid)
    else $error("result after final result");

endmodule

FILE: hdl/atil_cell.sv
// one row cell of the adjacency chain: holds a source id and its neighbor list
module atil_cell #(
  parameter int MAX_NEIGHBORS = 8,
  parameter int NODE_BITS     = 16,
  parameter int FW            = $clog2(MAX_NEIGHBORS + 1)
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  atil_pkg::tok_ctl_t                         ctl_in,
  input  logic [NODE_BITS-1:0]                       a_in,
  input  logic [NODE_BITS-1:0]                       b_in,
  input  logic [NODE_BITS-1:0]                       src_in,
  input  logic [FW-1:0]                              fill_in,
  input  logic [MAX_NEIGHBORS-1:0][NODE_BITS-1:0]    nbrs_in,
  output atil_pkg::tok_ctl_t                         ctl_out,
  output logic [NODE_BITS-1:0]                       a_out,
  output logic [NODE_BITS-1:0]                       b_out,
  output logic [NODE_BITS-1:0]                       src_out,
  output logic [FW-1:0]                              fill_out,
  output logic [MAX_NEIGHBORS-1:0][NODE_BITS-1:0]    nbrs_out
);
  import atil_pkg::*;

  // row contents
  logic                                    used;
  logic [NODE_BITS-1:0]                    src;
  logic [FW-1:0]                           fill;
  logic [MAX_NEIGHBORS-1:0][NODE_BITS-1:0] nbrs;

  logic                                    used_next;
  logic [NODE_BITS-1:0]                    src_next;
  logic [FW-1:0]                           fill_next;
  logic [MAX_NEIGHBORS-1:0][NODE_BITS-1:0] nbrs_next;

  tok_ctl_t                                ctl_next;
  logic [NODE_BITS-1:0]                    src_tok_next;
  logic [FW-1:0]                           fill_tok_next;
  logic [MAX_NEIGHBORS-1:0][NODE_BITS-1:0] nbrs_tok_next;

  logic live;
  logic hit;
  logic dup;
  logic full;

  always_comb begin
    live = ctl_in.vld && !ctl_in.done;
    hit  = live && used && (src == a_in);
    full = (fill == FW'(MAX_NEIGHBORS));
    dup  = 1'b0;
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      if ((FW'(i) < fill) && (nbrs[i] == b_in)) begin
        dup = 1'b1;
      end
    end

    used_next     = used;
    src_next      = src;
    fill_next     = fill;
    nbrs_next     = nbrs;
    ctl_next      = ctl_in;
    src_tok_next  = src_in;
    fill_tok_next = fill_in;
    nbrs_tok_next = nbrs_in;

    if (hit) begin
      ctl_next.done = 1'b1;
      if (ctl_in.op == OP_LIST) begin
        ctl_next.status = ST_ENTRY;
        src_tok_next    = src;
        fill_tok_next   = fill;
        nbrs_tok_next   = nbrs;
      end else if (dup) begin
        ctl_next.status = ST_DUP;
      end else if (full) begin
        ctl_next.status = ST_NOROOM;
      end else begin
        ctl_next.status = ST_ADDED;
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
          if (FW'(i) == fill) begin
            nbrs_next[i] = b_in;
          end
        end
        fill_next = FW'(fill + 1'b1);
      end
    end else if (live && !used && (ctl_in.op == OP_ADD)) begin
      // first free row: source is unknown, open a new row
      ctl_next.done   = 1'b1;
      ctl_next.status = ST_ADDED;
      used_next       = 1'b1;
      src_next        = a_in;
      nbrs_next[0]    = b_in;
      fill_next       = FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= 1'b0;
      fill        <= '0;
      ctl_out.vld <= 1'b0;
    end else begin
      used     <= used_next;
      fill     <= fill_next;
      ctl_out  <= ctl_next;
    end
    src      <= src_next;
    nbrs     <= nbrs_next;
    a_out    <= a_in;
    b_out    <= b_in;
    src_out  <= src_tok_next;
    fill_out <= fill_tok_next;
    nbrs_out <= nbrs_tok_next;
  end

endmodule

FILE: hdl/atil_emit.sv
// result sequencer: sends the status item or the listed row, one item a cycle while out_stall is low
module atil_emit #(
  parameter int MAX_NEIGHBORS = 8,
  parameter int NODE_BITS     = 16,
  parameter int FW            = $clog2(MAX_NEIGHBORS + 1)
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  atil_pkg::tok_ctl_t                      start,
  input  logic [NODE_BITS-1:0]                    src_in,
  input  logic [FW-1:0]                           fill_in,
  input  logic [MAX_NEIGHBORS-1:0][NODE_BITS-1:0] nbrs_in,
  input  logic                                    out_stall,
  output logic                                    out_valid,
  output logic [2:0]                              status,
  output logic [15:0]                             node_out,
  output logic                                    last
);
  import atil_pkg::*;

  localparam int NW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

  logic [FW-1:0]                           nxt;
  logic [FW-1:0]                           row_fill;
  logic [MAX_NEIGHBORS-1:0][NODE_BITS-1:0] row_nbrs;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      nxt       <= '0;
    end else if (start.vld) begin
      out_valid <= 1'b1;
      status    <= start.status;
      row_fill  <= fill_in;
      row_nbrs  <= nbrs_in;
      nxt       <= '0;
      if (start.status == ST_ENTRY) begin
        node_out <= 16'(src_in);
        last     <= (fill_in == '0);
      end else begin
        node_out <= '0;
        last     <= 1'b1;
      end
    end else if (out_valid && !out_stall) begin
      if (last) begin
        out_valid <= 1'b0;
      end else begin
        node_out <= 16'(row_nbrs[nxt[NW-1:0]]);
        last     <= (FW'(nxt + 1'b1) == row_fill);
        nxt      <= FW'(nxt + 1'b1);
      end
    end
  end

endmodule
